/* sv/cisf_pkg.sv */
// Shared types, register map and character helpers for the substring finder.
`timescale 1ns / 1ps

package cisf_pkg;

	localparam int OFFSET_W = 16;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;
	localparam int CFG_LEN_W = 5;

	// Register byte addresses (8 bytes per register).
	localparam logic [ADDR_W-1:0] ADDR_NEEDLE_LEN  = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_NEEDLE_LOW  = 5'd8;
	localparam logic [ADDR_W-1:0] ADDR_NEEDLE_HIGH = 5'd16;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_DELTA   = 8'd32;
	localparam logic [7:0] CHAR_NUL     = 8'h00;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] after_offset;
	} res_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return c + CASE_DELTA;
		end
		return c;
	endfunction

endpackage

/* sv/cisf_scan.sv */
// Window shift, position count and case-folded needle compare for one byte.
`timescale 1ns / 1ps

module cisf_scan #(
	parameter int MAX_NEEDLE = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [7:0]                         hay_byte,
	input  logic [cisf_pkg::CFG_LEN_W-1:0]     needle_length,
	input  logic [cisf_pkg::DATA_W-1:0]        needle_bytes_low,
	input  logic [cisf_pkg::DATA_W-1:0]        needle_bytes_high,
	output logic                               res_push,
	output cisf_pkg::res_t                     res_data
);

	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
	localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [7:0]            win_q [MAX_NEEDLE];
	logic [7:0]            win_n [MAX_NEEDLE];
	logic [7:0]            shifted [MAX_NEEDLE];
	logic [7:0]            needle_fold [MAX_NEEDLE];
	logic [COUNT_BITS-1:0] pos_q, pos_n, pos_inc;
	logic                  done_q, done_n;
	logic [LEN_W-1:0]      len_c;
	logic [IDX_W-1:0]      widx;
	logic                  hit;

	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_needle
		if (k < 8) begin : g_lo
			assign needle_fold[k] = cisf_pkg::fold(needle_bytes_low[8*k +: 8]);
		end else begin : g_hi
			assign needle_fold[k] = cisf_pkg::fold(needle_bytes_high[8*(k-8) +: 8]);
		end
	end

	assign len_c = (needle_length > cisf_pkg::CFG_LEN_W'(MAX_NEEDLE)) ?
		LEN_W'(MAX_NEEDLE) : LEN_W'(needle_length);

	always_comb begin
		shifted[0] = hay_byte;
		for (int j = 1; j < MAX_NEEDLE; j++) begin
			shifted[j] = win_q[j-1];
		end
		pos_inc = (pos_q == CNT_MAX) ? pos_q : pos_q + 1'b1;

		// needle char i lines up with window entry len-1-i
		hit  = 1'b1;
		widx = '0;
		for (int i = 0; i < MAX_NEEDLE; i++) begin
			if (LEN_W'(i) < len_c) begin
				widx = IDX_W'(len_c - LEN_W'(1) - LEN_W'(i));
				if (cisf_pkg::fold(shifted[widx]) != needle_fold[i]) begin
					hit = 1'b0;
				end
			end
		end
	end

	always_comb begin
		win_n    = win_q;
		pos_n    = pos_q;
		done_n   = done_q;
		res_push = 1'b0;
		res_data = '0;
		if (step) begin
			if (hay_byte == cisf_pkg::CHAR_NUL) begin
				res_push = !done_q;
				for (int j = 0; j < MAX_NEEDLE; j++) begin
					win_n[j] = '0;
				end
				pos_n  = '0;
				done_n = 1'b0;
			end else if (!done_q) begin
				win_n = shifted;
				pos_n = pos_inc;
				if (len_c != '0 && pos_inc >= COUNT_BITS'(len_c) && hit) begin
					done_n                = 1'b1;
					res_push              = 1'b1;
					res_data.found        = 1'b1;
					res_data.after_offset = cisf_pkg::OFFSET_W'(pos_inc);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_NEEDLE; j++) begin
				win_q[j] <= '0;
			end
			pos_q  <= '0;
			done_q <= 1'b0;
		end else begin
			win_q  <= win_n;
			pos_q  <= pos_n;
			done_q <= done_n;
		end
	end

endmodule

/* sv/cisf_outq.sv */
// Two-entry result queue that registers results toward the output channel.
`timescale 1ns / 1ps

module cisf_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cisf_pkg::res_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           res_valid,
	output cisf_pkg::res_t res_data
);

	cisf_pkg::res_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign res_valid = (cnt_q != 2'd0);
	assign res_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/case_insensitive_substring_find.sv */
// Top level: register port, input register, scan logic and result queue.
//
//  channel | direction | handshake             | payload
//  hay     | in        | hay_valid / hay_stall | hay_byte[7:0]
//  res     | out       | res_valid / res_stall | found, after_offset[15:0]
//  cfg     | in        | APB psel/penable      | 64-bit needle registers
//
// One byte per cycle while hay_stall is low; a result passes the input register, then the queue.
// The input register holds a byte only while two results sit unclaimed in the queue,
// so one result may wait on res_stall with no effect on the input side.
// Reset clears the window, position, match flag and needle registers at once.
`timescale 1ns / 1ps

module case_insensitive_substring_find #(
	parameter int MAX_NEEDLE = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              hay_valid,
	output logic                              hay_stall,
	input  logic [7:0]                        hay_byte,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              found,
	output logic [cisf_pkg::OFFSET_W-1:0]     after_offset,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cisf_pkg::ADDR_W-1:0]       paddr,
	input  logic [cisf_pkg::DATA_W-1:0]       pwdata,
	output logic [cisf_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [cisf_pkg::CFG_LEN_W-1:0] len_q;
	logic [cisf_pkg::DATA_W-1:0]    low_q, high_q;
	logic                           valid_s1;
	logic [7:0]                     hay_s1;
	logic                           adv, accept, pop, q_full, push;
	cisf_pkg::res_t                 push_data, q_data;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			cisf_pkg::ADDR_NEEDLE_LEN:  prdata = cisf_pkg::DATA_W'(len_q);
			cisf_pkg::ADDR_NEEDLE_LOW:  prdata = low_q;
			cisf_pkg::ADDR_NEEDLE_HIGH: prdata = high_q;
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				cisf_pkg::ADDR_NEEDLE_LEN:  len_q  <= pwdata[cisf_pkg::CFG_LEN_W-1:0];
				cisf_pkg::ADDR_NEEDLE_LOW:  low_q  <= pwdata;
				cisf_pkg::ADDR_NEEDLE_HIGH: high_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign pop       = res_valid && !res_stall;
	assign adv       = !q_full || pop;
	assign hay_stall = valid_s1 && !adv;
	assign accept    = hay_valid && !hay_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hay_s1 <= hay_byte;
		end
	end

	cisf_scan #(
		.MAX_NEEDLE(MAX_NEEDLE),
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && adv),
		.hay_byte         (hay_s1),
		.needle_length    (len_q),
		.needle_bytes_low (low_q),
		.needle_bytes_high(high_q),
		.res_push         (push),
		.res_data         (push_data)
	);

	cisf_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.res_valid(res_valid),
		.res_data (q_data)
	);

	assign found        = q_data.found;
	assign after_offset = q_data.after_offset;

endmodule

/* sv/cisf_check.sv */
// Port-level checks on the substring finder, bound to the top level.
`timescale 1ns / 1ps

module cisf_check (
	input logic        clk,
	input logic        arst_n,
	input logic        hay_valid,
	input logic        hay_stall,
	input logic [7:0]  hay_byte,
	input logic        res_valid,
	input logic        res_stall,
	input logic        found,
	input logic [15:0] after_offset
);

	// unmatched strings report a zero offset
	a_nomatch_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> after_offset == 16'd0)
		else $error("found=0 result with nonzero offset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(found) && $stable(after_offset))
		else $error("stalled result changed");

	// a fresh result comes from a byte transfer that passed the input register, then the queue
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) |-> $past(hay_valid && !hay_stall, 2))
		else $error("result without a matching byte transfer");

	a_nomatch_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !$past(res_valid) && !found |-> $past(hay_byte, 2) == 8'h00)
		else $error("found=0 result not caused by a terminator");

endmodule

bind case_insensitive_substring_find cisf_check u_cisf_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.hay_valid   (hay_valid),
	.hay_stall   (hay_stall),
	.hay_byte    (hay_byte),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.found       (found),
	.after_offset(after_offset)
);
